/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/cota_pkg.sv */
// ---------------------------------------------------------------------------
// cota_pkg
// Shared constants, types and helpers of the circle overlap admission table.
// ---------------------------------------------------------------------------
package cota_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int COORD_BITS = 16;
	localparam int EXT_W      = COORD_BITS + 1;
	localparam int RAD_W      = 15;
	localparam int RSUM_W     = RAD_W + 1;
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int RSQ_W      = 2 * RSUM_W;
	localparam int SUM_W      = SQ_W + 1;
	localparam int FIELD_W    = 16;
	localparam int SLOT_FW    = 4;
	localparam int CODE_W     = 3;

	localparam logic [CODE_W-1:0] CMD_INSERT     = 3'd0;
	localparam logic [CODE_W-1:0] CMD_REMOVE     = 3'd1;
	localparam logic [CODE_W-1:0] CMD_SET_CENTER = 3'd2;
	localparam logic [CODE_W-1:0] CMD_SET_RADIUS = 3'd3;
	localparam logic [CODE_W-1:0] CMD_TRANSLATE  = 3'd4;

	localparam logic [CODE_W-1:0] STAT_OK       = 3'd0;
	localparam logic [CODE_W-1:0] STAT_OVERLAP  = 3'd1;
	localparam logic [CODE_W-1:0] STAT_BAD_RAD  = 3'd2;
	localparam logic [CODE_W-1:0] STAT_FULL     = 3'd3;
	localparam logic [CODE_W-1:0] STAT_EMPTY    = 3'd4;
	localparam logic [CODE_W-1:0] STAT_RANGE    = 3'd5;

	localparam logic signed [EXT_W-1:0] CRD_MAX = EXT_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
	localparam logic signed [EXT_W-1:0] CRD_MIN = EXT_W'(-(64'sd1 <<< (COORD_BITS - 1)));

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic        [RAD_W-1:0]      r;
	} entry_t;

	// Scan control: clear restarts the clash flag, tap marks a read that counts.
	typedef struct packed {
		logic clear;
		logic tap;
	} scan_ctl_t;

	function automatic logic fits(input logic signed [EXT_W-1:0] v);
		return (v >= CRD_MIN) && (v <= CRD_MAX);
	endfunction

endpackage

/* rtl/core/cota_store.sv */
// ---------------------------------------------------------------------------
// cota_store
// Circle entry memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cota_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [cota_pkg::SLOT_W-1:0]   waddr,
	input  cota_pkg::entry_t              wdata,
	input  logic [cota_pkg::SLOT_W-1:0]   raddr,
	output cota_pkg::entry_t              rdata
);
	import cota_pkg::*;

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/cota_scan.sv */
// ---------------------------------------------------------------------------
// cota_scan
// Three-stage overlap test of the candidate circle against one stored entry
// per cycle, collecting any clash into a sticky flag.
// ---------------------------------------------------------------------------
module cota_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cota_pkg::scan_ctl_t   ctl,
	input  cota_pkg::entry_t      cand,
	input  cota_pkg::entry_t      ent,
	output logic                  clash
);
	import cota_pkg::*;

	logic                    tap_s1;
	logic                    tap_s2;
	logic                    tap_s3;
	logic signed [EXT_W-1:0] dx;
	logic signed [EXT_W-1:0] dy;
	logic signed [EXT_W-1:0] ndx;
	logic signed [EXT_W-1:0] ndy;
	logic [COORD_BITS-1:0]   adx_s2;
	logic [COORD_BITS-1:0]   ady_s2;
	logic [RSUM_W-1:0]       rs_s2;
	logic [SQ_W-1:0]         dx2_s3;
	logic [SQ_W-1:0]         dy2_s3;
	logic [RSQ_W-1:0]        rs2_s3;
	logic [SUM_W-1:0]        dist_sq;
	logic                    hit;
	logic                    clash_q;

	// Stage 1: the entry read arrives; form offset magnitudes and radius sum.
	assign dx  = EXT_W'(cand.cx) - EXT_W'(ent.cx);
	assign dy  = EXT_W'(cand.cy) - EXT_W'(ent.cy);
	assign ndx = -dx;
	assign ndy = -dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
			tap_s3 <= 1'b0;
		end else begin
			tap_s1 <= ctl.tap;
			tap_s2 <= tap_s1;
			tap_s3 <= tap_s2;
		end
	end

	always_ff @(posedge clk) begin
		adx_s2 <= dx[EXT_W-1] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		ady_s2 <= dy[EXT_W-1] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		rs_s2  <= RSUM_W'(cand.r) + RSUM_W'(ent.r);
		dx2_s3 <= adx_s2 * adx_s2;
		dy2_s3 <= ady_s2 * ady_s2;
		rs2_s3 <= rs_s2 * rs_s2;
	end

	// Touching counts as a clash, hence the inclusive compare.
	assign dist_sq = SUM_W'(dx2_s3) + SUM_W'(dy2_s3);
	assign hit     = tap_s3 && (dist_sq <= SUM_W'(rs2_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clash_q <= 1'b0;
		end else if (ctl.clear) begin
			clash_q <= 1'b0;
		end else if (hit) begin
			clash_q <= 1'b1;
		end
	end

	assign clash = clash_q;

endmodule

/* rtl/core/circle_overlap_admission_table_core.sv */
// Insert, set center, set radius and translate, once their checks pass, scan all 16
// entries, one read a cycle, through a 3-stage compare pipeline between lookup and
// commit; remove, unused commands and failed checks skip the scan.
// One command at a time: a new one is taken only after the last one commits; the
// single read port of the entry memory sets the scan length.
// Reset: arst_n clears all valid bits and control state at once; no clearing pass.
// ---------------------------------------------------------------------------
// circle_overlap_admission_table_core
// Table of non-overlapping circles with insert, remove, set center, set radius
// and translate commands, each admitted only after an overlap scan.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module circle_overlap_admission_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // slot[3:0], x[19:4], y[35:20], radius[51:36], zero
	input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // slot_out[3:0], zero
	output logic [2:0]  m_axis_tuser    // status[2:0]
);
	import cota_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOKUP = 6'b000010,
		S_PREP   = 6'b000100,
		S_SCAN   = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t                     state_q;
	logic [CODE_W-1:0]          cmd_q;
	logic [SLOT_FW-1:0]         slot_q;
	logic signed [FIELD_W-1:0]  x_q;
	logic signed [FIELD_W-1:0]  y_q;
	logic signed [FIELD_W-1:0]  r_q;
	logic [SLOTS-1:0]           valid_q;
	entry_t                     cand_q;
	logic [SLOT_W-1:0]          target_q;
	logic                       skip_en_q;
	logic                       scan_q;
	logic                       kill_q;
	logic [CODE_W-1:0]          status_q;
	logic [SLOT_FW-1:0]         slot_out_q;
	logic [SLOT_W-1:0]          idx_q;
	logic [1:0]                 drain_q;
	logic                       out_valid_q;
	logic [CODE_W-1:0]          out_status_q;
	logic [SLOT_FW-1:0]         out_slot_q;

	logic                       in_xfer;
	logic                       go;
	logic                       we;
	logic [SLOT_W-1:0]          slot_idx;
	logic                       live;
	logic                       free_found;
	logic [SLOT_W-1:0]          free_idx;
	logic [SLOT_W-1:0]          raddr;
	entry_t                     rdata;
	scan_ctl_t                  ctl;
	logic                       clash;
	logic signed [EXT_W-1:0]    x_ext;
	logic signed [EXT_W-1:0]    y_ext;
	logic signed [EXT_W-1:0]    nx;
	logic signed [EXT_W-1:0]    ny;
	logic [CODE_W-1:0]          prep_status;
	logic                       prep_scan;
	logic                       prep_kill;
	entry_t                     prep_cand;
	logic [SLOT_W-1:0]          prep_target;
	logic                       prep_skip;
	logic [SLOT_FW-1:0]         prep_slot_out;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign go            = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
	assign we            = go && scan_q && !clash;

	assign slot_idx = SLOT_W'(slot_q);
	assign live     = (int'(slot_q) < SLOTS) && valid_q[slot_idx];

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign raddr = (state_q == S_SCAN) ? idx_q : slot_idx;

	cota_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (target_q),
		.wdata (cand_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The addressed slot itself is left out of the scan for updates.
	assign ctl.clear = (state_q == S_PREP);
	assign ctl.tap   = (state_q == S_SCAN) && valid_q[idx_q]
	                   && !(skip_en_q && (idx_q == target_q));

	cota_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cand   (cand_q),
		.ent    (rdata),
		.clash  (clash)
	);

	assign x_ext = EXT_W'(x_q);
	assign y_ext = EXT_W'(y_q);
	assign nx    = EXT_W'(rdata.cx) + x_ext;
	assign ny    = EXT_W'(rdata.cy) + y_ext;

	// Checks in the order the command defines; the first failure wins.
	always_comb begin
		prep_status   = STAT_OK;
		prep_scan     = 1'b0;
		prep_kill     = 1'b0;
		prep_cand     = rdata;
		prep_target   = slot_idx;
		prep_skip     = 1'b1;
		prep_slot_out = slot_q;
		case (cmd_q)
			CMD_INSERT: begin
				prep_slot_out = free_found ? SLOT_FW'(free_idx) : '0;
				prep_target   = free_idx;
				prep_skip     = 1'b0;
				prep_cand.cx  = x_ext[COORD_BITS-1:0];
				prep_cand.cy  = y_ext[COORD_BITS-1:0];
				prep_cand.r   = r_q[RAD_W-1:0];
				if (r_q[FIELD_W-1]) begin
					prep_status = STAT_BAD_RAD;
				end else if (!fits(x_ext) || !fits(y_ext)) begin
					prep_status = STAT_RANGE;
				end else if (!free_found) begin
					prep_status = STAT_FULL;
				end else begin
					prep_scan = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!live) begin
					prep_status = STAT_EMPTY;
				end else begin
					prep_kill = 1'b1;
				end
			end
			CMD_SET_CENTER: begin
				prep_cand.cx = x_ext[COORD_BITS-1:0];
				prep_cand.cy = y_ext[COORD_BITS-1:0];
				if (!live) begin
					prep_status = STAT_EMPTY;
				end else if (!fits(x_ext) || !fits(y_ext)) begin
					prep_status = STAT_RANGE;
				end else begin
					prep_scan = 1'b1;
				end
			end
			CMD_SET_RADIUS: begin
				prep_cand.r = r_q[RAD_W-1:0];
				if (!live) begin
					prep_status = STAT_EMPTY;
				end else if (r_q[FIELD_W-1]) begin
					prep_status = STAT_BAD_RAD;
				end else begin
					prep_scan = 1'b1;
				end
			end
			CMD_TRANSLATE: begin
				prep_cand.cx = nx[COORD_BITS-1:0];
				prep_cand.cy = ny[COORD_BITS-1:0];
				if (!live) begin
					prep_status = STAT_EMPTY;
				end else if (!fits(nx) || !fits(ny)) begin
					prep_status = STAT_RANGE;
				end else begin
					prep_scan = 1'b1;
				end
			end
			default: begin
				prep_status = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q  <= s_axis_tuser;
			slot_q <= s_axis_tdata[3:0];
			x_q    <= s_axis_tdata[19:4];
			y_q    <= s_axis_tdata[35:20];
			r_q    <= s_axis_tdata[51:36];
		end
		if (state_q == S_PREP) begin
			cand_q     <= prep_cand;
			target_q   <= prep_target;
			skip_en_q  <= prep_skip;
			status_q   <= prep_status;
			slot_out_q <= prep_slot_out;
		end
		if (go) begin
			out_status_q <= (scan_q && clash) ? STAT_OVERLAP : status_q;
			out_slot_q   <= slot_out_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			scan_q      <= 1'b0;
			kill_q      <= 1'b0;
			idx_q       <= '0;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A commit refills the output register in the cycle it is read out.
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					scan_q  <= prep_scan;
					kill_q  <= prep_kill;
					idx_q   <= '0;
					drain_q <= '0;
					state_q <= prep_scan ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (go) begin
						if (we) begin
							valid_q[target_q] <= 1'b1;
						end
						if (kill_q) begin
							valid_q[target_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {4'b0000, out_slot_q};

	`ASSERT_CLK(a_valid_only_on_commit, clk, arst_n, (state_q != S_DONE) |=> $stable(valid_q), "valid bits changed outside commit")
	`ASSERT_CLK(a_result_after_commit, clk, arst_n, $rose(m_axis_tvalid) |-> $past(state_q == S_DONE), "result raised without a commit")
	`ASSERT_NEVER(a_insert_into_free, clk, arst_n, we && (cmd_q == CMD_INSERT) && valid_q[target_q], "insert wrote over a valid entry")

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the circle overlap admission table: directed command
// sequences, then constrained-random traffic under several idle and stall
// mixes. A shadow copy of the table predicts the status and slot of every reply.
// ---------------------------------------------------------------------------
module tb;
	import cota_pkg::*;

	localparam logic [CODE_W-1:0] CMD_SPARE_A = 3'd5;
	localparam logic [CODE_W-1:0] CMD_SPARE_B = 3'd6;
	localparam logic [CODE_W-1:0] CMD_SPARE_C = 3'd7;

	typedef struct {
		logic [CODE_W-1:0]         op;
		logic [SLOT_FW-1:0]        slot;
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] radius;
	} command_t;

	typedef struct {
		logic [CODE_W-1:0]  status;
		logic [SLOT_FW-1:0] slot_out;
	} reply_t;

	typedef struct {
		bit                        live;
		logic signed [FIELD_W-1:0] cx;
		logic signed [FIELD_W-1:0] cy;
		logic [RAD_W-1:0]          r;
	} circle_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	logic        rx_hold = 1'b0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          mismatches = 0;

	circle_t     shadow_circles[SLOTS];
	reply_t      expected_replies[$];

	circle_overlap_admission_table_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off when rx_hold is set.
	always @(posedge clk) begin
		m_axis_tready <= !rx_hold && (int'($urandom_range(99)) >= stall_pct);
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("tb: mismatch: %s", msg);
	endtask

	// Two circles clash when the squared center distance does not exceed the
	// squared radius sum, so touching counts as a clash.
	function automatic bit clashes_with_table(input longint cx, input longint cy,
			input longint r, input int skip);
		int j;
		longint dx, dy, rs;
		for (j = 0; j < SLOTS; j++) begin
			if (!shadow_circles[j].live || j == skip)
				continue;
			dx = cx - longint'(shadow_circles[j].cx);
			dy = cy - longint'(shadow_circles[j].cy);
			rs = r + longint'(shadow_circles[j].r);
			if (dx * dx + dy * dy <= rs * rs)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Applies one command to the shadow table and returns the reply it earns.
	function automatic reply_t admit_command(input command_t c);
		reply_t rep;
		int     j, free_slot, s;
		longint nx, ny;
		rep.status = STAT_OK;
		rep.slot_out = c.slot;
		s = c.slot;
		case (c.op)
			CMD_INSERT: begin
				free_slot = -1;
				for (j = SLOTS - 1; j >= 0; j--)
					if (!shadow_circles[j].live)
						free_slot = j;
				rep.slot_out = (free_slot < 0) ? '0 : SLOT_FW'(free_slot);
				// Insert coordinates come in at full width, so the range check
				// cannot fail here.
				if (c.radius < 0)
					rep.status = STAT_BAD_RAD;
				else if (free_slot < 0)
					rep.status = STAT_FULL;
				else if (clashes_with_table(longint'(c.x), longint'(c.y),
						longint'(c.radius), -1))
					rep.status = STAT_OVERLAP;
				else begin
					shadow_circles[free_slot].live = 1'b1;
					shadow_circles[free_slot].cx = c.x;
					shadow_circles[free_slot].cy = c.y;
					shadow_circles[free_slot].r = c.radius[RAD_W-1:0];
				end
			end
			CMD_REMOVE, CMD_SET_CENTER, CMD_SET_RADIUS, CMD_TRANSLATE: begin
				if (!shadow_circles[s].live)
					rep.status = STAT_EMPTY;
				else if (c.op == CMD_REMOVE)
					shadow_circles[s].live = 1'b0;
				else if (c.op == CMD_SET_RADIUS) begin
					if (c.radius < 0)
						rep.status = STAT_BAD_RAD;
					else if (clashes_with_table(longint'(shadow_circles[s].cx),
							longint'(shadow_circles[s].cy), longint'(c.radius), s))
						rep.status = STAT_OVERLAP;
					else
						shadow_circles[s].r = c.radius[RAD_W-1:0];
				end else begin
					nx = longint'(c.x);
					ny = longint'(c.y);
					if (c.op == CMD_TRANSLATE) begin
						nx = nx + longint'(shadow_circles[s].cx);
						ny = ny + longint'(shadow_circles[s].cy);
					end
					if (nx < longint'(CRD_MIN) || nx > longint'(CRD_MAX) ||
							ny < longint'(CRD_MIN) || ny > longint'(CRD_MAX))
						rep.status = STAT_RANGE;
					else if (clashes_with_table(nx, ny,
							longint'(shadow_circles[s].r), s))
						rep.status = STAT_OVERLAP;
					else begin
						shadow_circles[s].cx = FIELD_W'(nx);
						shadow_circles[s].cy = FIELD_W'(ny);
					end
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	function automatic command_t make_command(input logic [CODE_W-1:0] op,
			input int slot, input int x, input int y, input int radius);
		command_t c;
		c.op = op;
		c.slot = SLOT_FW'(slot);
		c.x = FIELD_W'(x);
		c.y = FIELD_W'(y);
		c.radius = FIELD_W'(radius);
		return c;
	endfunction

	// Sender: optional random gap, then hold the transfer until it is taken.
	task automatic send_command(input command_t c);
		int gap;
		gap = 0;
		while (int'($urandom_range(99)) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, c.radius, c.y, c.x, c.slot};
		s_axis_tuser <= c.op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_replies.push_back(admit_command(c));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_replies.size() == 0)
				note_mismatch("result arrived with nothing outstanding");
			else begin
				want = expected_replies.pop_front();
				if (m_axis_tuser !== want.status)
					note_mismatch($sformatf("status %0d, expected %0d",
						m_axis_tuser, want.status));
				if (m_axis_tdata[SLOT_FW-1:0] !== want.slot_out)
					note_mismatch($sformatf("slot_out %0d, expected %0d",
						m_axis_tdata[SLOT_FW-1:0], want.slot_out));
			end
		end
	end

	function automatic logic signed [FIELD_W-1:0] near_coord();
		return FIELD_W'(int'($urandom_range(4000)) - 2000);
	endfunction

	// Mostly a slot that holds a circle, so updates get past the empty check.
	function automatic logic [SLOT_FW-1:0] pick_slot();
		int                 n;
		logic [SLOT_FW-1:0] s;
		s = SLOT_FW'($urandom_range(SLOTS - 1));
		if ($urandom_range(9) == 0)
			return s;
		for (n = 0; n < 2 * SLOTS; n++) begin
			if (shadow_circles[s].live)
				return s;
			s = SLOT_FW'($urandom_range(SLOTS - 1));
		end
		return s;
	endfunction

	function automatic command_t draw_command();
		command_t c;
		int       pick, j, k, rsum;
		pick = $urandom_range(99);
		c.slot = pick_slot();
		c.x = near_coord();
		c.y = near_coord();
		c.radius = FIELD_W'($urandom_range(400));
		if ($urandom_range(11) == 0)
			c.radius = -c.radius - 1;
		if (pick < 28)
			c.op = CMD_INSERT;
		else if (pick < 38)
			c.op = CMD_REMOVE;
		else if (pick < 52)
			c.op = CMD_SET_CENTER;
		else if (pick < 66)
			c.op = CMD_SET_RADIUS;
		else if (pick < 82) begin
			c.op = CMD_TRANSLATE;
			c.x = FIELD_W'(int'($urandom_range(600)) - 300);
			c.y = FIELD_W'(int'($urandom_range(600)) - 300);
			if ($urandom_range(7) == 0) begin
				c.x = FIELD_W'($urandom());
				c.y = FIELD_W'($urandom());
			end
		end else if (pick < 90) begin
			// Place the candidate on a 3-4-5 offset so that it exactly touches
			// a stored circle, or clears it by one.
			c.op = CMD_INSERT;
			j = pick_slot();
			k = $urandom_range(1, 120);
			if (shadow_circles[j].live) begin
				c.x = FIELD_W'(int'(shadow_circles[j].cx) + ($urandom_range(1) ? 3 * k : -3 * k));
				c.y = FIELD_W'(int'(shadow_circles[j].cy) + ($urandom_range(1) ? 4 * k : -4 * k));
				rsum = 5 * k - int'(shadow_circles[j].r) - int'($urandom_range(1));
				c.radius = FIELD_W'((rsum < 0) ? 0 : rsum);
			end
		end else if (pick < 95) begin
			c.op = CMD_INSERT;
			c.x = FIELD_W'($urandom());
			c.y = FIELD_W'($urandom());
			c.radius = FIELD_W'($urandom_range(32767));
		end else begin
			c.op = CODE_W'($urandom_range(7));
			c.slot = SLOT_FW'($urandom_range(SLOTS - 1));
			c.x = FIELD_W'($urandom());
			c.y = FIELD_W'($urandom());
			c.radius = FIELD_W'($urandom());
		end
		return c;
	endfunction

	task automatic test_insert_rules();
		send_command(make_command(CMD_INSERT, 0, 0, 0, 0));
		send_command(make_command(CMD_INSERT, 0, 0, 0, 0));
		send_command(make_command(CMD_INSERT, 0, 100, 0, -32768));
		send_command(make_command(CMD_INSERT, 0, -32768, -32768, 0));
		send_command(make_command(CMD_INSERT, 0, 32767, 32767, 32767));
		send_command(make_command(CMD_INSERT, 0, 0, 5, 5));
		send_command(make_command(CMD_INSERT, 0, 0, 6, 5));
	endtask

	task automatic test_update_rules();
		send_command(make_command(CMD_REMOVE, 15, 0, 0, 0));
		send_command(make_command(CMD_SET_CENTER, 14, 1, 1, 0));
		send_command(make_command(CMD_SET_RADIUS, 13, 0, 0, -1));
		send_command(make_command(CMD_TRANSLATE, 12, 1, 1, 0));
		send_command(make_command(CMD_SET_RADIUS, 0, 0, 0, -1));
		send_command(make_command(CMD_TRANSLATE, 2, 1, 0, 0));
		send_command(make_command(CMD_TRANSLATE, 1, -1, 0, 0));
		send_command(make_command(CMD_TRANSLATE, 2, -32768, -32768, 0));
		send_command(make_command(CMD_SET_CENTER, 0, 0, 11, 0));
		send_command(make_command(CMD_SET_CENTER, 0, 0, -100, 0));
		send_command(make_command(CMD_SET_RADIUS, 3, 0, 0, 32767));
		send_command(make_command(CMD_SET_RADIUS, 3, 0, 0, 100));
		send_command(make_command(CMD_TRANSLATE, 3, 0, -6, 0));
		send_command(make_command(CMD_TRANSLATE, 3, 0, 1, 0));
		send_command(make_command(CMD_REMOVE, 1, 0, 0, 0));
		send_command(make_command(CMD_INSERT, 0, -32768, 32767, 0));
	endtask

	task automatic test_spare_commands();
		send_command(make_command(CMD_SPARE_A, 9, 1, 2, 3));
		send_command(make_command(CMD_SPARE_B, 10, -1, -2, -3));
		send_command(make_command(CMD_SPARE_C, 15, 32767, -32768, 0));
	endtask

	task automatic test_table_full();
		int s;
		for (s = 0; s < SLOTS; s++)
			send_command(make_command(CMD_REMOVE, s, 0, 0, 0));
		for (s = 0; s < SLOTS; s++)
			send_command(make_command(CMD_INSERT, 0, -24000 + 3000 * s, -20000, 100 + s));
		send_command(make_command(CMD_INSERT, 0, 0, 0, 5));
		send_command(make_command(CMD_INSERT, 0, 0, 0, -5));
		send_command(make_command(CMD_REMOVE, 7, 0, 0, 0));
		send_command(make_command(CMD_INSERT, 0, 0, 30000, 9));
	endtask

	task automatic test_random_traffic(input int count);
		int n;
		for (n = 0; n < count; n++)
			send_command(draw_command());
	endtask

	// The receiver holds off while the sender keeps offering commands.
	task automatic test_backpressure();
		fork
			begin
				rx_hold <= 1'b1;
				repeat (300) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		test_random_traffic(25);
	endtask

	task automatic test_drain_pause();
		test_random_traffic(12);
		wait_drained();
		test_random_traffic(12);
	endtask

	initial begin
		int j;
		for (j = 0; j < SLOTS; j++)
			shadow_circles[j].live = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_insert_rules();
		test_update_rules();
		test_spare_commands();
		test_table_full();

		test_random_traffic(330);
		send_idle_pct = 64;
		test_random_traffic(330);
		send_idle_pct = 0;
		stall_pct = 64;
		test_random_traffic(330);
		send_idle_pct = 18;
		stall_pct = 18;
		test_random_traffic(330);
		test_backpressure();
		test_drain_pause();

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
